>>> hdl/m3i_pkg.sv
// Package for the 3x3 adjugate matrix inverse.
// Holds formats, pipeline depths, the cofactor index tables and the item
// type that crosses the queue. No dependencies.
package m3i_pkg;

  // Element format
  localparam int ElemW  = 32;
  localparam int FracB  = 16;
  localparam int NElem  = 9;

  // Exact intermediate widths
  localparam int ProdW  = 2 * ElemW;          // element times element
  localparam int CofW   = ProdW + 1;          // difference of two products
  localparam int PartW  = ElemW + 33;         // element times cofactor half
  localparam int DetW   = ElemW + CofW + 1;   // sum of three element-cofactor products
  localparam int MagW   = CofW - 1;           // cofactor magnitude
  localparam int DShift = 2 * FracB;          // cofactor and det fraction scaling
  localparam int RemW   = MagW + DShift;      // divider remainder
  localparam int DMagW  = DetW - 1;           // determinant magnitude
  localparam int QW     = ElemW + 1;          // quotient bits kept (one overflow bit)
  localparam int CmpW   = DMagW + QW;         // divider compare width
  localparam int DShW   = DetW - DShift;      // determinant after the fraction shift

  // Pipeline depths
  localparam int FrontLat = 5;
  localparam int QDepth   = 8;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int NStep    = QW;
  // Accept edge to the edge that samples the result strobe
  localparam int Latency  = FrontLat + 4 + NStep;

  // Saturation limits
  localparam logic [QW-1:0] QPosMax = QW'((64'd1 << (ElemW - 1)) - 64'd1);
  localparam logic [QW-1:0] QNegMax = QW'(64'd1 << (ElemW - 1));

  // Cofactor k = e[CA0]*e[CA1] - e[CB0]*e[CB1], elements row-major
  typedef logic [3:0] eidx_t;
  localparam eidx_t CA0 [NElem] = '{4'd4, 4'd7, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam eidx_t CA1 [NElem] = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam eidx_t CB0 [NElem] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd1};
  localparam eidx_t CB1 [NElem] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd3};

  // One classified item between front and back
  typedef struct packed {
    logic [NElem-1:0][CofW-1:0] cof;
    logic [DetW-1:0]            det;
    logic                       singular;
  } m3i_item_t;

endpackage

>>> hdl/m3i_front.sv
// Front part: cofactors and exact determinant, then singular classification.
// Five register stages, one item per cycle. Depends on m3i_pkg.
module m3i_front
  import m3i_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [NElem-1:0][ElemW-1:0] elem,
  output logic                        push,
  output m3i_item_t                   push_item
);

  logic signed [ElemW-1:0] a [NElem];
  logic signed [ProdW-1:0] pa_r [NElem];
  logic signed [ProdW-1:0] pb_r [NElem];
  logic signed [CofW-1:0]  cof2_r [NElem];
  logic signed [CofW-1:0]  cof3_r [NElem];
  logic signed [CofW-1:0]  cof4_r [NElem];
  logic signed [CofW-1:0]  cof5_r [NElem];
  logic signed [ElemW-1:0] col1_r [3];
  logic signed [ElemW-1:0] col2_r [3];
  logic signed [PartW-1:0] plo_r [3];
  logic signed [PartW-1:0] phi_r [3];
  logic signed [DetW-1:0]  term_r [3];
  logic signed [DetW-1:0]  det_r;
  logic [FrontLat-1:0]     vld_r;
  logic [FrontLat-1:0]     vld_nxt;

  always_comb begin
    for (int k = 0; k < NElem; k++) a[k] = $signed(elem[k]);
  end

  // Advance the valid chain
  always_comb begin
    vld_nxt = {vld_r[FrontLat-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  // Stage 1: eighteen element products
  always_ff @(posedge clk) begin
    for (int k = 0; k < NElem; k++) begin
      pa_r[k] <= ProdW'(a[CA0[k]]) * ProdW'(a[CA1[k]]);
      pb_r[k] <= ProdW'(a[CB0[k]]) * ProdW'(a[CB1[k]]);
    end
    col1_r[0] <= a[0];
    col1_r[1] <= a[3];
    col1_r[2] <= a[6];
  end

  // Stage 2: cofactors
  always_ff @(posedge clk) begin
    for (int k = 0; k < NElem; k++) cof2_r[k] <= CofW'(pa_r[k]) - CofW'(pb_r[k]);
    col2_r <= col1_r;
  end

  // Stage 3: first-column elements times cofactor halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      plo_r[j] <= PartW'(col2_r[j]) * PartW'($signed({1'b0, cof2_r[j][31:0]}));
      phi_r[j] <= PartW'(col2_r[j]) * PartW'($signed(cof2_r[j][CofW-1:32]));
    end
    cof3_r <= cof2_r;
  end

  // Stage 4: join halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      term_r[j] <= (DetW'(phi_r[j]) <<< 32) + DetW'(plo_r[j]);
    end
    cof4_r <= cof3_r;
  end

  // Stage 5: determinant
  always_ff @(posedge clk) begin
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    cof5_r <= cof4_r;
  end

  // Classify and hand to the queue
  always_comb begin
    for (int k = 0; k < NElem; k++) push_item.cof[k] = cof5_r[k];
    push_item.det      = det_r;
    push_item.singular = (det_r == '0);
    push               = vld_r[FrontLat-1];
  end

endmodule

>>> hdl/m3i_queue.sv
// Short queue between front and back; the back drains one item per cycle.
// Registered read. Depends on m3i_pkg.
module m3i_queue
  import m3i_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  m3i_item_t push_item,
  output logic      pop_valid,
  output m3i_item_t pop_item,
  output logic      busy
);

  m3i_item_t        mem [QDepth];
  logic [QPtrW-1:0] wptr_r, wptr_nxt;
  logic [QPtrW-1:0] rptr_r, rptr_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic             pop_valid_r;
  logic             busy_r, busy_nxt;

  assign pop = (cnt_r != '0);

  // Pointers and fill count
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    // Hold off new items while the queue could not take all in-flight items
    busy_nxt = (cnt_nxt > (QPtrW+1)'(QDepth - FrontLat - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      cnt_r       <= '0;
      pop_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      cnt_r       <= cnt_nxt;
      pop_valid_r <= pop;
      busy_r      <= busy_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_item;
    if (pop) pop_item <= mem[rptr_r];
  end

  assign pop_valid = pop_valid_r;
  assign busy      = busy_r;

endmodule

>>> hdl/m3i_back.sv
// Back part: signs and magnitudes, nine restoring dividers one quotient bit
// per stage, determinant shift, saturation. Depends on m3i_pkg.
module m3i_back
  import m3i_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  m3i_item_t                   item,
  output logic                        res_valid,
  output logic [NElem-1:0][ElemW-1:0] res_inv,
  output logic [ElemW-1:0]            res_det,
  output logic                        res_singular,
  output logic                        res_saturated
);

  logic [NElem-1:0][RemW-1:0] rem_r  [NStep+1];
  logic [NElem-1:0][QW-1:0]   quo_r  [NStep+1];
  logic [DMagW-1:0]           dmag_r [NStep+1];
  logic [NElem-1:0]           neg_r  [NStep+1];
  logic [ElemW-1:0]           detq_r [NStep+1];
  logic                       dsat_r [NStep+1];
  logic                       sing_r [NStep+1];
  logic [NStep:0]             vld_r;

  logic                       dneg;
  logic [DetW-1:0]            dneg_full;
  logic signed [DShW-1:0]     dsh;
  logic [NElem-1:0][RemW-1:0] rem0;
  logic [NElem-1:0]           neg0;
  logic [CofW-1:0]            cneg [NElem];
  logic [ElemW-1:0]           detq0;
  logic                       dsat0;

  logic [NElem-1:0][ElemW-1:0] inv_nxt;
  logic                        sat_nxt;

  logic [NElem-1:0][ElemW-1:0] inv_r;
  logic [ElemW-1:0]            det_r;
  logic                        sing_out_r;
  logic                        sat_r;
  logic                        valid_r;

  // Prepare signs, magnitudes and the shifted determinant
  always_comb begin
    dneg      = item.det[DetW-1];
    dneg_full = '0 - item.det;
    dsh       = DShW'($signed(item.det) >>> DShift);
    for (int k = 0; k < NElem; k++) begin
      cneg[k] = '0 - item.cof[k];
      neg0[k] = item.cof[k][CofW-1] ^ dneg;
      rem0[k] = {(item.cof[k][CofW-1] ? cneg[k][MagW-1:0] : item.cof[k][MagW-1:0]),
                 {DShift{1'b0}}};
    end
    if (dsh > DShW'($signed(QPosMax))) begin
      dsat0 = 1'b1;
      detq0 = QPosMax[ElemW-1:0];
    end else if (dsh < -DShW'($signed(QNegMax))) begin
      dsat0 = 1'b1;
      detq0 = QNegMax[ElemW-1:0];
    end else begin
      dsat0 = 1'b0;
      detq0 = dsh[ElemW-1:0];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[NStep-1:0], in_valid};
  end

  // Divider entry stage
  always_ff @(posedge clk) begin
    rem_r[0]  <= rem0;
    quo_r[0]  <= '0;
    dmag_r[0] <= dneg ? dneg_full[DMagW-1:0] : item.det[DMagW-1:0];
    neg_r[0]  <= neg0;
    detq_r[0] <= detq0;
    dsat_r[0] <= dsat0;
    sing_r[0] <= item.singular;
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < NStep; s++) begin : g_step
    localparam int Bit = NStep - 1 - s;
    logic [CmpW-1:0]            dsub;
    logic [NElem-1:0][RemW-1:0] rem_nxt;
    logic [NElem-1:0][QW-1:0]   quo_nxt;
    logic [CmpW-1:0]            diff [NElem];

    always_comb begin
      dsub = CmpW'(dmag_r[s]) << Bit;
      for (int k = 0; k < NElem; k++) begin
        diff[k]    = CmpW'(rem_r[s][k]) - dsub;
        rem_nxt[k] = rem_r[s][k];
        quo_nxt[k] = quo_r[s][k];
        if (CmpW'(rem_r[s][k]) >= dsub) begin
          rem_nxt[k]      = diff[k][RemW-1:0];
          quo_nxt[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1]  <= rem_nxt;
      quo_r[s+1]  <= quo_nxt;
      dmag_r[s+1] <= dmag_r[s];
      neg_r[s+1]  <= neg_r[s];
      detq_r[s+1] <= detq_r[s];
      dsat_r[s+1] <= dsat_r[s];
      sing_r[s+1] <= sing_r[s];
    end
  end

  // Saturate quotients, zero everything for a singular matrix
  always_comb begin
    logic [QW-1:0] nq;
    sat_nxt = dsat_r[NStep];
    for (int k = 0; k < NElem; k++) begin
      nq = '0 - quo_r[NStep][k];
      if (neg_r[NStep][k]) begin
        if (quo_r[NStep][k] > QNegMax) begin
          sat_nxt    = 1'b1;
          inv_nxt[k] = QNegMax[ElemW-1:0];
        end else begin
          inv_nxt[k] = nq[ElemW-1:0];
        end
      end else begin
        if (quo_r[NStep][k] > QPosMax) begin
          sat_nxt    = 1'b1;
          inv_nxt[k] = QPosMax[ElemW-1:0];
        end else begin
          inv_nxt[k] = quo_r[NStep][k][ElemW-1:0];
        end
      end
    end
    if (sing_r[NStep]) begin
      inv_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= vld_r[NStep];
    inv_r      <= inv_nxt;
    det_r      <= sing_r[NStep] ? '0 : detq_r[NStep];
    sing_out_r <= sing_r[NStep];
    sat_r      <= sat_nxt;
  end

  assign res_valid     = valid_r;
  assign res_inv       = inv_r;
  assign res_det       = det_r;
  assign res_singular  = sing_out_r;
  assign res_saturated = sat_r;

endmodule

>>> hdl/matrix3_inverse_adjugate.sv
// Top level of the 3x3 adjugate matrix inverse, Q16.16 elements.
// Instantiates m3i_front, m3i_queue and m3i_back; depends on m3i_pkg.
//
//   channel   ports                                 accepted when
//   input     start, busy, in_r0c0..in_r2c2         start && !busy at clk edge
//   result    out_valid, out_inv_*, out_determinant, out_valid high (one cycle)
//             out_singular, out_saturated
//
// One item per cycle while busy is low; each result follows its accept edge through
// five front stages, the queue, one prepare stage, 33 divider stages (one
// quotient bit each, the nine dividers side by side) and the result register.
// rst_n is synchronous and clears only the valid and queue control.
// The receiver cannot stall; busy rises only if the queue could overflow.
module matrix3_inverse_adjugate
  import m3i_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_r0c0,
  input  logic [31:0] in_r0c1,
  input  logic [31:0] in_r0c2,
  input  logic [31:0] in_r1c0,
  input  logic [31:0] in_r1c1,
  input  logic [31:0] in_r1c2,
  input  logic [31:0] in_r2c0,
  input  logic [31:0] in_r2c1,
  input  logic [31:0] in_r2c2,
  output logic        out_valid,
  output logic [31:0] out_inv_r0c0,
  output logic [31:0] out_inv_r0c1,
  output logic [31:0] out_inv_r0c2,
  output logic [31:0] out_inv_r1c0,
  output logic [31:0] out_inv_r1c1,
  output logic [31:0] out_inv_r1c2,
  output logic [31:0] out_inv_r2c0,
  output logic [31:0] out_inv_r2c1,
  output logic [31:0] out_inv_r2c2,
  output logic [31:0] out_determinant,
  output logic        out_singular,
  output logic        out_saturated
);

  logic                        accept;
  logic [NElem-1:0][ElemW-1:0] elem;
  logic                        push;
  m3i_item_t                   push_item;
  logic                        pop_valid;
  m3i_item_t                   pop_item;
  logic [NElem-1:0][ElemW-1:0] inv;

  assign accept = start && !busy;
  assign elem   = {in_r2c2, in_r2c1, in_r2c0, in_r1c2, in_r1c1, in_r1c0,
                   in_r0c2, in_r0c1, in_r0c0};

  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .elem      (elem),
    .push      (push),
    .push_item (push_item)
  );

  m3i_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .busy      (busy)
  );

  m3i_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pop_valid),
    .item          (pop_item),
    .res_valid     (out_valid),
    .res_inv       (inv),
    .res_det       (out_determinant),
    .res_singular  (out_singular),
    .res_saturated (out_saturated)
  );

  assign out_inv_r0c0 = inv[0];
  assign out_inv_r0c1 = inv[1];
  assign out_inv_r0c2 = inv[2];
  assign out_inv_r1c0 = inv[3];
  assign out_inv_r1c1 = inv[4];
  assign out_inv_r1c2 = inv[5];
  assign out_inv_r2c0 = inv[6];
  assign out_inv_r2c1 = inv[7];
  assign out_inv_r2c2 = inv[8];

endmodule

>>> hdl/m3i_check.sv
// Port-level checker for matrix3_inverse_adjugate, with its bind.
// Depends on m3i_pkg.
module m3i_check
  import m3i_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_inv_r0c0,
  input logic [31:0] out_inv_r1c1,
  input logic [31:0] out_inv_r2c2,
  input logic [31:0] out_determinant,
  input logic        out_singular,
  input logic        out_saturated
);

  // Every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(Latency) out_valid)
    else $error("result strobe missing after accept");

  // No strobe without an accepted item
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result strobe without accepted item");

  // Singular results carry a zero determinant, zero diagonal entries and no saturation
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_determinant == '0 && !out_saturated &&
      out_inv_r0c0 == '0 && out_inv_r1c1 == '0 && out_inv_r2c2 == '0))
    else $error("singular result not cleared");

  // The queue keeps up, so the block never holds off
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind matrix3_inverse_adjugate m3i_check u_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_inv_r0c0    (out_inv_r0c0),
  .out_inv_r1c1    (out_inv_r1c1),
  .out_inv_r2c2    (out_inv_r2c2),
  .out_determinant (out_determinant),
  .out_singular    (out_singular),
  .out_saturated   (out_saturated)
);
